// ===== design/fir_pkg.sv =====
package fir_pkg;

    localparam int TAP_COUNT    = 32;
    localparam int TAP_W        = $clog2(TAP_COUNT);

    localparam int RING_DEPTH   = 32;
    localparam int RING_AW      = $clog2(RING_DEPTH);

    localparam int SAMPLE_W     = 16;
    localparam int COEF_W       = 16;
    localparam int TAPS_PER_REG = 4;
    localparam int COEF_REGS    = 8;
    localparam int COEF_TAPS    = COEF_REGS * TAPS_PER_REG;
    localparam int CFG_W        = COEF_W * TAPS_PER_REG;
    localparam int CFG_IDX_W    = $clog2(COEF_REGS);

    localparam int PROD_W       = SAMPLE_W + COEF_W;
    localparam int ACC_W        = PROD_W + TAP_W;
    localparam int Q_SHIFT      = 14;

    localparam logic [SAMPLE_W-1:0] OUT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] OUT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

endpackage

// ===== design/fir_ram.sv =====
module fir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/fir_32tap_q14_saturating.sv =====
// channel     | dir | handshake                    | payload
// ------------+-----+------------------------------+------------------------------------
// s_axis      | in  | s_axis_tvalid/s_axis_tready  | tdata[15:0] sample_in
// m_axis      | out | m_axis_tvalid/m_axis_tready  | tdata[15:0] filtered_sample
// cfg         | in  | cfg_wr_en (no wait)          | cfg_index, cfg_wr_data (coefs, 4 each)
//
// the single shared multiply-accumulate walks the taps one per cycle behind the
// registered ram read.
// the history ram needs no clearing pass: per-entry valid bits, cleared by reset,
// make unwritten slots read as zero.
// a new word is taken as soon as the previous one is in the output register;
// a stalled result only holds back the end of the next computation.
module fir_32tap_q14_saturating (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,   // [15:0] sample_in
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [15:0]                         m_axis_tdata,   // [15:0] filtered_sample
    input  logic                                cfg_wr_en,
    input  logic [fir_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fir_pkg::CFG_W-1:0]           cfg_wr_data
);

    import fir_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t                 state_reg;
    logic [CFG_W-1:0]       coef_reg [COEF_REGS];
    coef_t                  coef_tap [COEF_TAPS];
    logic [RING_DEPTH-1:0]  valid_reg;
    logic [RING_AW-1:0]     wp_reg;
    logic [RING_AW-1:0]     pos_reg;
    logic [TAP_W-1:0]       issue_cnt_reg;
    logic [TAP_W-1:0]       tap_d_reg;
    logic                   rd_v_reg;
    logic                   slot_ok_reg;
    logic                   prod_v_reg;
    prod_t                  prod_reg;
    prod_t                  prod_next;
    acc_t                   acc_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_W-1:0]    out_data_reg;

    logic                   in_fire;
    logic                   issue;
    logic [RING_AW-1:0]     rd_addr;
    logic [SAMPLE_W-1:0]    rd_data;
    sample_t                tap_sample;
    logic [ACC_W-Q_SHIFT-SAMPLE_W:0] top_bits;
    logic [SAMPLE_W-1:0]    sat_value;
    logic                   out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign issue         = (state_reg == ST_RUN);
    assign rd_addr       = pos_reg - RING_AW'(issue_cnt_reg);
    assign out_free      = !out_valid_reg || m_axis_tready;

    fir_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_history (
        .clk     (clk),
        .wr_en   (in_fire),
        .wr_addr (wp_reg),
        .wr_data (s_axis_tdata),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        for (int k = 0; k < COEF_TAPS; k++)
        begin
            coef_tap[k] = coef_reg[k / TAPS_PER_REG][(k % TAPS_PER_REG) * COEF_W +: COEF_W];
        end
    end

    // slots never written read as zero
    assign tap_sample = slot_ok_reg ? sample_t'(rd_data) : '0;
    assign prod_next  = tap_sample * coef_tap[RING_AW'(tap_d_reg)];

    // saturate when the bits above the kept field are not all sign copies
    assign top_bits = acc_reg[ACC_W-1:Q_SHIFT+SAMPLE_W-1];
    always_comb
    begin
        if ((&top_bits) || !(|top_bits))
        begin
            sat_value = acc_reg[Q_SHIFT +: SAMPLE_W];
        end
        else if (acc_reg[ACC_W-1])
        begin
            sat_value = OUT_MIN;
        end
        else
        begin
            sat_value = OUT_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COEF_REGS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            coef_reg[cfg_index] <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            wp_reg        <= '0;
            issue_cnt_reg <= '0;
            rd_v_reg      <= 1'b0;
            prod_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg   <= issue;
            prod_v_reg <= rd_v_reg;
            if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        valid_reg[wp_reg] <= 1'b1;
                        wp_reg            <= wp_reg + 1'b1;
                        issue_cnt_reg     <= '0;
                        state_reg         <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    issue_cnt_reg <= issue_cnt_reg + 1'b1;
                    if (issue_cnt_reg == TAP_W'(TAP_COUNT - 1))
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!rd_v_reg && !prod_v_reg)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pos_reg <= wp_reg;
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (issue)
        begin
            tap_d_reg   <= issue_cnt_reg;
            slot_ok_reg <= valid_reg[rd_addr];
        end
        if (rd_v_reg)
        begin
            prod_reg <= prod_next;
        end
        if (state_reg == ST_FINISH && out_free)
        begin
            out_data_reg <= sat_value;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // mac pipe must be empty whenever a new word can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !rd_v_reg && !prod_v_reg)
        else $error("mac pipe busy in idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> wp_reg == $past(wp_reg) + 1'b1)
        else $error("write position did not advance");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg) == ST_FINISH)
        else $error("result posted outside finish");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> issue_cnt_reg <= TAP_W'(TAP_COUNT - 1))
        else $error("tap counter overran");

endmodule
